@@ sv/mpf_pkg.sv @@
// Shared constants and types for the multiway partition fitness scorer.
// No dependencies; imported by multiway_partition_fitness_top.
package mpf_pkg;

  // Pile and field geometry
  localparam int MAX_PILES   = 8;
  localparam int MAX_GENES   = 128;
  localparam int PILE_W      = 3;
  localparam int WEIGHT_W    = 16;
  localparam int NUM_PILES_W = 4;
  localparam int SUM_W       = 23;
  localparam int FIT_W       = 26;

  // Derived counts for the fitness adder tree
  localparam int NUM_DIFFS = MAX_PILES - 1;
  localparam int NUM_PAIRS = (NUM_DIFFS + 1) / 2;
  localparam int PAIR_W    = SUM_W + 1;

  // Reset value of the pile count register
  localparam logic [NUM_PILES_W-1:0] NUM_PILES_RST = NUM_PILES_W'(2);

  // Saturation level of one pile sum and bound on the fitness
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [FIT_W-1:0] FIT_MAX = FIT_W'(NUM_DIFFS * ((1 << SUM_W) - 1));

  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [PAIR_W-1:0]      pair_t;
  typedef logic [FIT_W-1:0]       fit_t;
  typedef logic [NUM_PILES_W-1:0] pcount_t;

endpackage

@@ sv/multiway_partition_fitness_top.sv @@
// Multiway partition fitness scorer: pile accumulation and fitness pipeline.
// Depends on mpf_pkg for widths, constants and types.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one gene per transaction:
//   in_item_weight, in_pile_index and in_is_last. The weight is added with
//   saturation to its pile's running sum; a pile at or above the count in
//   cfg register num_piles adds nothing and raises bad_pile for the
//   individual. The gene marked last closes the individual.
//   Result channel (out_valid / out_stall) carries one transaction per
//   individual: out_fitness, the sum of absolute differences of adjacent
//   pile sums, and out_bad_pile.
//   Configuration: cfg_we with cfg_wdata writes num_piles (reset 2, values
//   above 8 act as 8); write it only while the block is idle.
// Timing:
//   One gene per cycle sustained while in_stall is low. A last gene passes
//   through input register, accumulate and snapshot, absolute differences,
//   pair sums and result register to out_valid. The pile sums are cleared
//   in the cycle the last gene is folded in, so the next individual follows
//   with no gap.
// Reset and stall:
//   rst_n clears all pile sums, the error flag and every stage valid.
//   A stall on the result side holds the result and backs up through the
//   pipeline stages; in_stall rises only once the last-gene path is full.
module multiway_partition_fitness_top
  import mpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [NUM_PILES_W-1:0] cfg_wdata,
  // gene channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [WEIGHT_W-1:0] in_item_weight,
  input  logic [PILE_W-1:0]   in_pile_index,
  input  logic                in_is_last,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FIT_W-1:0]    out_fitness,
  output logic                out_bad_pile
);

  // ---------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------
  pcount_t               num_piles_r;

  logic                  g_valid_r;
  logic [WEIGHT_W-1:0]   g_weight_r;
  logic [PILE_W-1:0]     g_pile_r;
  logic                  g_last_r;

  sum_t                  pile_sums_r   [MAX_PILES];
  sum_t                  pile_sums_nxt [MAX_PILES];
  sum_t                  pile_upd      [MAX_PILES];
  logic                  err_r;
  logic                  err_nxt;

  logic                  snap_v_r;
  sum_t                  snap_sums_r [MAX_PILES];
  logic                  snap_err_r;
  pcount_t               snap_k_r;

  logic                  diff_v_r;
  sum_t                  diff_r   [NUM_DIFFS];
  sum_t                  diff_nxt [NUM_DIFFS];
  logic                  diff_err_r;

  logic                  pair_v_r;
  pair_t                 pair_r   [NUM_PAIRS];
  pair_t                 pair_nxt [NUM_PAIRS];
  logic                  pair_err_r;

  logic                  out_valid_r;
  fit_t                  out_fitness_r;
  fit_t                  fit_nxt;
  logic                  out_bad_pile_r;

  pcount_t               k_eff;
  logic                  g_in_range;
  logic                  g_take;
  logic                  g_fire;
  logic                  snap_load;
  logic                  in_load;
  logic                  out_rdy;
  logic                  pair_rdy;
  logic                  diff_rdy;
  logic                  snap_rdy;
  logic                  sums_zero;

  // ---------------------------------------------------------------
  // Stage readiness, back to front
  // ---------------------------------------------------------------
  assign out_rdy  = !out_valid_r || !out_stall;
  assign pair_rdy = !pair_v_r || out_rdy;
  assign diff_rdy = !diff_v_r || pair_rdy;
  assign snap_rdy = !snap_v_r || diff_rdy;

  // Non-last genes never wait; a last gene needs the snapshot slot
  assign g_take    = !g_last_r || snap_rdy;
  assign g_fire    = g_valid_r && g_take;
  assign snap_load = g_fire && g_last_r;
  assign in_stall  = g_valid_r && !g_take;
  assign in_load   = in_valid && !in_stall;

  // ---------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_piles_r <= NUM_PILES_RST;
    end else if (cfg_we) begin
      num_piles_r <= cfg_wdata;
    end
  end

  // Clamp the pile count to the number of physical piles
  assign k_eff      = (num_piles_r > pcount_t'(MAX_PILES)) ? pcount_t'(MAX_PILES)
                                                           : num_piles_r;
  assign g_in_range = pcount_t'(g_pile_r) < k_eff;

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (in_load) begin
      g_valid_r <= 1'b1;
    end else if (g_fire) begin
      g_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      g_weight_r <= in_item_weight;
      g_pile_r   <= in_pile_index;
      g_last_r   <= in_is_last;
    end
  end

  // ---------------------------------------------------------------
  // Accumulate: saturating add into the addressed pile
  // ---------------------------------------------------------------
  always_comb begin
    logic [SUM_W:0] s;
    for (int i = 0; i < MAX_PILES; i++) begin
      s = {1'b0, pile_sums_r[i]} + (SUM_W+1)'(g_weight_r);
      if (g_fire && g_in_range && (g_pile_r == PILE_W'(i))) begin
        pile_upd[i] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
      end else begin
        pile_upd[i] = pile_sums_r[i];
      end
      // Clear live sums once the individual is handed to the snapshot
      pile_sums_nxt[i] = snap_load ? '0 : pile_upd[i];
    end
  end

  always_comb begin
    err_nxt = err_r;
    if (g_fire) begin
      err_nxt = snap_load ? 1'b0 : (err_r || !g_in_range);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PILES; i++) begin
        pile_sums_r[i] <= '0;
      end
      err_r <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_PILES; i++) begin
        pile_sums_r[i] <= pile_sums_nxt[i];
      end
      err_r <= err_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Snapshot of the finished individual
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (snap_load) begin
      snap_v_r <= 1'b1;
    end else if (diff_rdy) begin
      snap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      for (int i = 0; i < MAX_PILES; i++) begin
        snap_sums_r[i] <= pile_upd[i];
      end
      snap_err_r <= err_r || !g_in_range;
      snap_k_r   <= k_eff;
    end
  end

  // ---------------------------------------------------------------
  // Absolute differences of adjacent piles in use
  // ---------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NUM_DIFFS; i++) begin
      if (pcount_t'(i + 1) >= snap_k_r) begin
        diff_nxt[i] = '0;
      end else if (snap_sums_r[i] >= snap_sums_r[i+1]) begin
        diff_nxt[i] = snap_sums_r[i] - snap_sums_r[i+1];
      end else begin
        diff_nxt[i] = snap_sums_r[i+1] - snap_sums_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_v_r <= 1'b0;
    end else if (diff_rdy) begin
      diff_v_r <= snap_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (diff_rdy && snap_v_r) begin
      for (int i = 0; i < NUM_DIFFS; i++) begin
        diff_r[i] <= diff_nxt[i];
      end
      diff_err_r <= snap_err_r;
    end
  end

  // ---------------------------------------------------------------
  // First adder level: sum differences in pairs, odd one passes through
  // ---------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < NUM_PAIRS; j++) begin
      pair_nxt[j] = PAIR_W'(diff_r[2*j]);
    end
    for (int j = 0; j < NUM_DIFFS / 2; j++) begin
      pair_nxt[j] = PAIR_W'(diff_r[2*j]) + PAIR_W'(diff_r[2*j+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_v_r <= 1'b0;
    end else if (pair_rdy) begin
      pair_v_r <= diff_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_rdy && diff_v_r) begin
      for (int j = 0; j < NUM_PAIRS; j++) begin
        pair_r[j] <= pair_nxt[j];
      end
      pair_err_r <= diff_err_r;
    end
  end

  // ---------------------------------------------------------------
  // Final adder level into the result register
  // ---------------------------------------------------------------
  always_comb begin
    fit_nxt = '0;
    for (int j = 0; j < NUM_PAIRS; j++) begin
      fit_nxt = fit_nxt + FIT_W'(pair_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= pair_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && pair_v_r) begin
      out_fitness_r  <= fit_nxt;
      out_bad_pile_r <= pair_err_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_fitness  = out_fitness_r;
  assign out_bad_pile = out_bad_pile_r;

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  always_comb begin
    sums_zero = !err_r;
    for (int i = 0; i < MAX_PILES; i++) begin
      sums_zero = sums_zero && (pile_sums_r[i] == '0);
    end
  end

  // Closing an individual leaves clean sums and flag for the next one
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    snap_load |=> sums_zero)
    else $error("pile sums not cleared after last gene");

  // An out-of-range gene inside an individual is remembered
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (g_fire && !g_last_r && !g_in_range) |=> err_r)
    else $error("out-of-range pile not flagged");

  // Only a waiting last gene may hold off the input side
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (g_valid_r && g_last_r && snap_v_r))
    else $error("input stalled without a blocked last gene");

  // Fitness never exceeds the bound set by saturated pile sums
  a_fit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fitness_r <= FIT_MAX))
    else $error("fitness above its bound");

endmodule
